// ----- rtl/cau_pkg.sv -----
package cau_pkg;

    // request type codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;
    localparam logic [2:0] OP_CONJ  = 3'd5;

    localparam int unsigned OP_WIDTH = 3;

endpackage

// ----- rtl/complex_arith_unit_core.sv -----
// throughput: one request per cycle while the output is not stalled; the restoring divider is unrolled into
//   DATA_WIDTH + 1 registered steps, one quotient bit each, so it never blocks
// a stall at the output freezes the whole pipeline
// reset clears only the stage valid bits; payload registers are not reset
module complex_arith_unit_core #(
    parameter int unsigned DATA_WIDTH = 16,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [cau_pkg::OP_WIDTH-1:0]    i_req_type,
    input  logic signed [DATA_WIDTH-1:0]    i_a_re,
    input  logic signed [DATA_WIDTH-1:0]    i_a_im,
    input  logic signed [DATA_WIDTH-1:0]    i_b_re,
    input  logic signed [DATA_WIDTH-1:0]    i_b_im,
    input  logic signed [DATA_WIDTH-1:0]    i_scale,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [DATA_WIDTH-1:0]    o_res_re,
    output logic signed [DATA_WIDTH-1:0]    o_res_im,
    output logic                            o_overflow,
    output logic                            o_div_zero
);

    localparam int unsigned W   = DATA_WIDTH;
    localparam int unsigned MW  = 2 * W + 1;           // signed sum of two products
    localparam int unsigned DW  = 2 * W;               // divisor magnitude
    localparam int unsigned XW  = 3 * W + FRAC_BITS + 1; // divider remainder
    localparam int unsigned QW  = W + 1;               // quotient bits incl. overflow bit
    localparam int unsigned NS  = QW;                  // divider steps
    localparam int unsigned SW  = 2 * W + 5;           // side data carried past divider

    // ------------------------------------------------------------------
    // saturate a sign/magnitude value to W bits; msb of result is overflow
    // ------------------------------------------------------------------
    function automatic logic [W:0] f_sat(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0]  lim;
        logic [MW-1:0]  negv;
        logic [W-1:0]   val;
        logic           ovf;
        lim  = MW'(1) << (W - 1);
        negv = MW'(0) - mag;
        ovf  = 1'b0;
        if (!neg) begin
            if (mag > lim - MW'(1)) begin
                ovf = 1'b1;
                val = {1'b0, {(W-1){1'b1}}};
            end else begin
                val = mag[W-1:0];
            end
        end else begin
            if (mag > lim) begin
                ovf = 1'b1;
                val = {1'b1, {(W-1){1'b0}}};
            end else begin
                val = negv[W-1:0];
            end
        end
        return {ovf, val};
    endfunction

    // global advance: the pipeline moves unless the result is held
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // ------------------------------------------------------------------
    // stage 1: request register
    // ------------------------------------------------------------------
    logic                           r_s1_valid;
    logic [cau_pkg::OP_WIDTH-1:0]   r_s1_op;
    logic signed [W-1:0]            r_s1_a_re;
    logic signed [W-1:0]            r_s1_a_im;
    logic signed [W-1:0]            r_s1_b_re;
    logic signed [W-1:0]            r_s1_b_im;
    logic signed [W-1:0]            r_s1_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op    <= i_req_type;
            r_s1_a_re  <= i_a_re;
            r_s1_a_im  <= i_a_im;
            r_s1_b_re  <= i_b_re;
            r_s1_b_im  <= i_b_im;
            r_s1_scale <= i_scale;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: full-width products, plus the linear ops alongside
    // ------------------------------------------------------------------
    logic signed [2*W-1:0]          w_p_rr;
    logic signed [2*W-1:0]          w_p_ii;
    logic signed [2*W-1:0]          w_p_ri;
    logic signed [2*W-1:0]          w_p_ir;
    logic signed [2*W-1:0]          w_sq_r;
    logic signed [2*W-1:0]          w_sq_i;

    cau_mul #(
        .DATA_WIDTH (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_op    (r_s1_op),
        .i_a_re  (r_s1_a_re),
        .i_a_im  (r_s1_a_im),
        .i_b_re  (r_s1_b_re),
        .i_b_im  (r_s1_b_im),
        .i_scale (r_s1_scale),
        .o_p_rr  (w_p_rr),
        .o_p_ii  (w_p_ii),
        .o_p_ri  (w_p_ri),
        .o_p_ir  (w_p_ir),
        .o_sq_r  (w_sq_r),
        .o_sq_i  (w_sq_i)
    );

    logic                           r_s2_valid;
    logic [cau_pkg::OP_WIDTH-1:0]   r_s2_op;
    logic signed [W:0]              r_s2_lin_re;
    logic signed [W:0]              r_s2_lin_im;
    logic signed [W:0]              n_s2_lin_re;
    logic signed [W:0]              n_s2_lin_im;
    logic signed [W:0]              w_ar_x;
    logic signed [W:0]              w_ai_x;
    logic signed [W:0]              w_br_x;
    logic signed [W:0]              w_bi_x;

    always_comb begin
        w_ar_x = {r_s1_a_re[W-1], r_s1_a_re};
        w_ai_x = {r_s1_a_im[W-1], r_s1_a_im};
        w_br_x = {r_s1_b_re[W-1], r_s1_b_re};
        w_bi_x = {r_s1_b_im[W-1], r_s1_b_im};
        case (r_s1_op)
            cau_pkg::OP_ADD: begin
                n_s2_lin_re = w_ar_x + w_br_x;
                n_s2_lin_im = w_ai_x + w_bi_x;
            end
            cau_pkg::OP_SUB: begin
                n_s2_lin_re = w_ar_x - w_br_x;
                n_s2_lin_im = w_ai_x - w_bi_x;
            end
            cau_pkg::OP_CONJ: begin
                n_s2_lin_re = w_ar_x;
                n_s2_lin_im = -w_ai_x;
            end
            default: begin
                n_s2_lin_re = '0;
                n_s2_lin_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op     <= r_s1_op;
            r_s2_lin_re <= n_s2_lin_re;
            r_s2_lin_im <= n_s2_lin_im;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: combine products, finish non-divide ops, set up divider
    // ------------------------------------------------------------------
    logic signed [MW-1:0]   w_val_re;
    logic signed [MW-1:0]   w_val_im;
    logic                   w_neg_re;
    logic                   w_neg_im;
    logic [MW-1:0]          w_mag_re;
    logic [MW-1:0]          w_mag_im;
    logic [MW-1:0]          w_tmag_re;
    logic [MW-1:0]          w_tmag_im;
    logic [W:0]             w_sat_re;
    logic [W:0]             w_sat_im;
    logic [DW-1:0]          w_den;
    logic                   w_is_div;
    logic                   w_dz;
    logic [SW-1:0]          n_s3_side;

    always_comb begin
        case (r_s2_op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
                w_val_re = MW'(r_s2_lin_re);
                w_val_im = MW'(r_s2_lin_im);
            end
            cau_pkg::OP_MUL: begin
                w_val_re = MW'(w_p_rr) - MW'(w_p_ii);
                w_val_im = MW'(w_p_ri) + MW'(w_p_ir);
            end
            cau_pkg::OP_DIV: begin
                // a times conjugate of b
                w_val_re = MW'(w_p_rr) + MW'(w_p_ii);
                w_val_im = MW'(w_p_ir) - MW'(w_p_ri);
            end
            cau_pkg::OP_SCALE: begin
                w_val_re = MW'(w_p_rr);
                w_val_im = MW'(w_p_ir);
            end
            default: begin
                w_val_re = '0;
                w_val_im = '0;
            end
        endcase

        w_neg_re = w_val_re[MW-1];
        w_neg_im = w_val_im[MW-1];
        w_mag_re = w_neg_re ? MW'(-w_val_re) : MW'(w_val_re);
        w_mag_im = w_neg_im ? MW'(-w_val_im) : MW'(w_val_im);

        // products carry twice the fraction bits: truncate toward zero
        if (r_s2_op == cau_pkg::OP_MUL || r_s2_op == cau_pkg::OP_SCALE) begin
            w_tmag_re = w_mag_re >> FRAC_BITS;
            w_tmag_im = w_mag_im >> FRAC_BITS;
        end else begin
            w_tmag_re = w_mag_re;
            w_tmag_im = w_mag_im;
        end

        w_sat_re = f_sat(w_neg_re, w_tmag_re);
        w_sat_im = f_sat(w_neg_im, w_tmag_im);

        w_den    = DW'(w_sq_r) + DW'(w_sq_i);
        w_is_div = (r_s2_op == cau_pkg::OP_DIV);
        w_dz     = w_is_div && (w_den == '0);

        // side: res_re, res_im, overflow, div_zero, divide active, signs
        if (w_is_div) begin
            n_s3_side = {{(2*W+1){1'b0}}, w_dz, !w_dz, w_neg_re, w_neg_im};
        end else begin
            n_s3_side = {w_sat_re[W-1:0], w_sat_im[W-1:0],
                         w_sat_re[W] | w_sat_im[W], 1'b0, 1'b0, 1'b0, 1'b0};
        end
    end

    logic                   r_s3_valid;
    logic [XW-1:0]          r_s3_rem_re;
    logic [XW-1:0]          r_s3_rem_im;
    logic [DW-1:0]          r_s3_den;
    logic [SW-1:0]          r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_rem_re <= XW'(w_mag_re) << FRAC_BITS;
            r_s3_rem_im <= XW'(w_mag_im) << FRAC_BITS;
            r_s3_den    <= w_den;
            r_s3_side   <= n_s3_side;
        end
    end

    // ------------------------------------------------------------------
    // divider: one restoring step per stage, msb first; the first step
    // only flags a quotient beyond the result range
    // ------------------------------------------------------------------
    logic               w_dv_valid [NS+1];
    logic [XW-1:0]      w_dv_rem_re [NS+1];
    logic [XW-1:0]      w_dv_rem_im [NS+1];
    logic [DW-1:0]      w_dv_den [NS+1];
    logic [QW-1:0]      w_dv_q_re [NS+1];
    logic [QW-1:0]      w_dv_q_im [NS+1];
    logic [SW-1:0]      w_dv_side [NS+1];

    assign w_dv_valid[0]  = r_s3_valid;
    assign w_dv_rem_re[0] = r_s3_rem_re;
    assign w_dv_rem_im[0] = r_s3_rem_im;
    assign w_dv_den[0]    = r_s3_den;
    assign w_dv_q_re[0]   = '0;
    assign w_dv_q_im[0]   = '0;
    assign w_dv_side[0]   = r_s3_side;

    for (genvar g = 0; g < NS; g++) begin : g_div
        cau_div_step #(
            .XW (XW),
            .DW (DW),
            .QW (QW),
            .SW (SW),
            .K  (QW - 1 - g)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_dv_valid[g]),
            .i_rem_re (w_dv_rem_re[g]),
            .i_rem_im (w_dv_rem_im[g]),
            .i_den    (w_dv_den[g]),
            .i_q_re   (w_dv_q_re[g]),
            .i_q_im   (w_dv_q_im[g]),
            .i_side   (w_dv_side[g]),
            .o_valid  (w_dv_valid[g+1]),
            .o_rem_re (w_dv_rem_re[g+1]),
            .o_rem_im (w_dv_rem_im[g+1]),
            .o_den    (w_dv_den[g+1]),
            .o_q_re   (w_dv_q_re[g+1]),
            .o_q_im   (w_dv_q_im[g+1]),
            .o_side   (w_dv_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: saturate quotients, merge with pass-through results
    // ------------------------------------------------------------------
    logic [SW-1:0]      w_fs;
    logic [W:0]         w_qs_re;
    logic [W:0]         w_qs_im;
    logic [W-1:0]       n_res_re;
    logic [W-1:0]       n_res_im;
    logic               n_ovf;
    logic               n_dz;

    always_comb begin
        w_fs    = w_dv_side[NS];
        w_qs_re = f_sat(w_fs[1], MW'(w_dv_q_re[NS]));
        w_qs_im = f_sat(w_fs[0], MW'(w_dv_q_im[NS]));
        if (w_fs[2]) begin
            n_res_re = w_qs_re[W-1:0];
            n_res_im = w_qs_im[W-1:0];
            n_ovf    = w_qs_re[W] | w_qs_im[W];
        end else begin
            n_res_re = w_fs[SW-1 -: W];
            n_res_im = w_fs[SW-1-W -: W];
            n_ovf    = w_fs[4];
        end
        n_dz = w_fs[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_dv_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_res_re   <= n_res_re;
            o_res_im   <= n_res_im;
            o_overflow <= n_ovf;
            o_div_zero <= n_dz;
        end
    end

endmodule

// ----- rtl/cau_mul.sv -----
module cau_mul #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [cau_pkg::OP_WIDTH-1:0]        i_op,
    input  logic signed [DATA_WIDTH-1:0]        i_a_re,
    input  logic signed [DATA_WIDTH-1:0]        i_a_im,
    input  logic signed [DATA_WIDTH-1:0]        i_b_re,
    input  logic signed [DATA_WIDTH-1:0]        i_b_im,
    input  logic signed [DATA_WIDTH-1:0]        i_scale,
    output logic signed [2*DATA_WIDTH-1:0]      o_p_rr,
    output logic signed [2*DATA_WIDTH-1:0]      o_p_ii,
    output logic signed [2*DATA_WIDTH-1:0]      o_p_ri,
    output logic signed [2*DATA_WIDTH-1:0]      o_p_ir,
    output logic signed [2*DATA_WIDTH-1:0]      o_sq_r,
    output logic signed [2*DATA_WIDTH-1:0]      o_sq_i
);

    logic signed [DATA_WIDTH-1:0]   w_bx;

    // scale reuses the b_re multipliers
    assign w_bx = (i_op == cau_pkg::OP_SCALE) ? i_scale : i_b_re;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p_rr <= i_a_re * w_bx;
            o_p_ii <= i_a_im * i_b_im;
            o_p_ri <= i_a_re * i_b_im;
            o_p_ir <= i_a_im * w_bx;
            o_sq_r <= i_b_re * i_b_re;
            o_sq_i <= i_b_im * i_b_im;
        end
    end

endmodule

// ----- rtl/cau_div_step.sv -----
module cau_div_step #(
    parameter int unsigned XW = 57,
    parameter int unsigned DW = 32,
    parameter int unsigned QW = 17,
    parameter int unsigned SW = 37,
    parameter int unsigned K  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [XW-1:0]   i_rem_re,
    input  logic [XW-1:0]   i_rem_im,
    input  logic [DW-1:0]   i_den,
    input  logic [QW-1:0]   i_q_re,
    input  logic [QW-1:0]   i_q_im,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [XW-1:0]   o_rem_re,
    output logic [XW-1:0]   o_rem_im,
    output logic [DW-1:0]   o_den,
    output logic [QW-1:0]   o_q_re,
    output logic [QW-1:0]   o_q_im,
    output logic [SW-1:0]   o_side
);

    // top step only detects a quotient too large for the result
    localparam bit TOP = (K == QW - 1);

    logic [XW-1:0]  w_sh;
    logic           w_ge_re;
    logic           w_ge_im;
    logic [XW-1:0]  n_rem_re;
    logic [XW-1:0]  n_rem_im;
    logic [QW-1:0]  n_q_re;
    logic [QW-1:0]  n_q_im;

    always_comb begin
        w_sh    = XW'(i_den) << K;
        w_ge_re = (i_rem_re >= w_sh);
        w_ge_im = (i_rem_im >= w_sh);
        n_rem_re = (w_ge_re && !TOP) ? (i_rem_re - w_sh) : i_rem_re;
        n_rem_im = (w_ge_im && !TOP) ? (i_rem_im - w_sh) : i_rem_im;
        n_q_re    = i_q_re;
        n_q_re[K] = w_ge_re;
        n_q_im    = i_q_im;
        n_q_im[K] = w_ge_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem_re <= n_rem_re;
            o_rem_im <= n_rem_im;
            o_den    <= i_den;
            o_q_re   <= n_q_re;
            o_q_im   <= n_q_im;
            o_side   <= i_side;
        end
    end

endmodule

// ----- bench/complex_arith_unit_core_tb.sv -----
`timescale 1ns / 100ps

module complex_arith_unit_core_tb;

    localparam int DW        = 16;
    localparam int FB        = 8;
    localparam int OPW       = cau_pkg::OP_WIDTH;
    localparam int N_RANDOM  = 1850;
    localparam int WD_LIMIT  = 2000;
    localparam int DRAIN     = 40;

    // codes outside the operation set
    localparam logic [OPW-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPW-1:0] OP_SPARE_HI = 3'd7;

    // one operand set as presented to the unit
    typedef struct packed {
        logic [OPW-1:0]       kind;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
        logic signed [DW-1:0] scale;
    } t_operands;

    // one complex answer with its flags
    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 ovf;
        logic                 dz;
    } t_answer;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [OPW-1:0]        i_req_type;
    logic signed [DW-1:0]  i_a_re, i_a_im, i_b_re, i_b_im, i_scale;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [DW-1:0]  o_res_re, o_res_im;
    logic                  o_overflow, o_div_zero;

    t_operands pending_requests[$];
    t_answer   expected_answers[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        stimulus_loaded = 1'b0;
    int        send_wait = 0;
    int        recv_wait = 0;

    complex_arith_unit_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_a_re(i_a_re), .i_a_im(i_a_im),
        .i_b_re(i_b_re), .i_b_im(i_b_im), .i_scale(i_scale),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_res_re(o_res_re), .o_res_im(o_res_im),
        .o_overflow(o_overflow), .o_div_zero(o_div_zero)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // clamp a wide signed value into the result width, noting any clipping
    function automatic logic signed [DW-1:0] clip(input longint v, inout logic ovf);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (DW-1)) - 1;
        lo = -(64'sd1 <<< (DW-1));
        if (v > hi) begin
            ovf = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // drop fraction bits rounding toward zero
    function automatic longint drop_frac(input longint v);
        if (v < 0) return -((-v) >>> FB);
        return v >>> FB;
    endfunction

    // exact (num * 2^FB) / den truncated toward zero
    function automatic longint frac_quot(input longint num, input longint den);
        longint m;
        m = (num < 0) ? -num : num;
        m = (m <<< FB) / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic t_answer complex_result(input t_operands x);
        t_answer r;
        longint ar, ai, br, bi, sc, den;
        ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im; sc = x.scale;
        r = '0;
        case (x.kind)
            cau_pkg::OP_ADD: begin
                r.re = clip(ar + br, r.ovf);
                r.im = clip(ai + bi, r.ovf);
            end
            cau_pkg::OP_SUB: begin
                r.re = clip(ar - br, r.ovf);
                r.im = clip(ai - bi, r.ovf);
            end
            cau_pkg::OP_MUL: begin
                r.re = clip(drop_frac(ar * br - ai * bi), r.ovf);
                r.im = clip(drop_frac(ar * bi + ai * br), r.ovf);
            end
            cau_pkg::OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    r.re = clip(frac_quot(ar * br + ai * bi, den), r.ovf);
                    r.im = clip(frac_quot(ai * br - ar * bi, den), r.ovf);
                end
            end
            cau_pkg::OP_SCALE: begin
                r.re = clip(drop_frac(ar * sc), r.ovf);
                r.im = clip(drop_frac(ai * sc), r.ovf);
            end
            cau_pkg::OP_CONJ: begin
                r.re = x.a_re;
                r.im = clip(-ai, r.ovf);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return DW'($urandom_range(0, 1023) - 512);
            default: return DW'($urandom());
        endcase
    endfunction

    task automatic add_request(input logic [OPW-1:0] k, input logic signed [DW-1:0] ar,
                               input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                               input logic signed [DW-1:0] bi, input logic signed [DW-1:0] sc);
        t_operands x;
        x.kind = k; x.a_re = ar; x.a_im = ai; x.b_re = br; x.b_im = bi; x.scale = sc;
        pending_requests.push_back(x);
    endtask

    // stimulus: directed corners, then random requests
    initial begin
        t_operands x;
        // every operation at the extremes
        add_request(cau_pkg::OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, '0);
        add_request(cau_pkg::OP_ADD, 16'sh0100, 16'shff00, 16'sh0080, 16'sh0080, '0);
        add_request(cau_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, '0);
        add_request(cau_pkg::OP_SUB, 16'sh0300, 16'sh0001, 16'sh0100, 16'sh0002, '0);
        add_request(cau_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, '0);
        add_request(cau_pkg::OP_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, '0);
        add_request(cau_pkg::OP_MUL, 16'sh0100, 16'sh0200, 16'shff00, 16'sh0080, '0);
        add_request(cau_pkg::OP_MUL, 16'shffff, 16'sh0000, 16'sh0001, 16'sh0000, '0);
        // divide: zero divisor, tiny divisor, full-scale
        add_request(cau_pkg::OP_DIV, 16'sh1234, 16'sh5678, 16'sh0000, 16'sh0000, '0);
        add_request(cau_pkg::OP_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, '0);
        add_request(cau_pkg::OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000, '0);
        add_request(cau_pkg::OP_DIV, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, '0);
        add_request(cau_pkg::OP_DIV, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, '0);
        add_request(cau_pkg::OP_DIV, 16'shffff, 16'sh0001, 16'sh0003, 16'shfffd, '0);
        add_request(cau_pkg::OP_DIV, 16'sh0300, 16'shfd00, 16'sh0000, 16'sh0001, '0);
        add_request(cau_pkg::OP_SCALE, 16'sh7fff, 16'sh8000, '0, '0, 16'sh8000);
        add_request(cau_pkg::OP_SCALE, 16'sh7fff, 16'sh8000, '0, '0, 16'sh7fff);
        add_request(cau_pkg::OP_SCALE, 16'shffff, 16'sh0001, '0, '0, 16'sh0080);
        add_request(cau_pkg::OP_CONJ, 16'sh8000, 16'sh8000, '0, '0, '0);
        add_request(cau_pkg::OP_CONJ, 16'sh7fff, 16'sh7fff, '0, '0, '0);
        // codes outside the operation set answer zero
        add_request(OP_SPARE_LO, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_request(OP_SPARE_HI, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        for (int n = 0; n < N_RANDOM; n++) begin
            x.kind  = ($urandom_range(0, 19) == 0) ? OPW'($urandom_range(6, 7))
                                                   : OPW'($urandom_range(0, 5));
            x.a_re  = pick_value();
            x.a_im  = pick_value();
            x.b_re  = pick_value();
            x.b_im  = pick_value();
            x.scale = pick_value();
            // a fair share of zero divisors
            if (x.kind == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
                x.b_re = '0;
                x.b_im = '0;
            end
            pending_requests.push_back(x);
        end
        stimulus_loaded = 1'b1;
    end

    // reset held for the first cycles
    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: presents requests with a random gap before each
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_answers.push_back(complex_result({i_req_type, i_a_re, i_a_im,
                                                           i_b_re, i_b_im, i_scale}));
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    i_valid   <= 1'b0;
                end else if (stimulus_loaded && pending_requests.size() > 0) begin
                    t_operands x;
                    x = pending_requests.pop_front();
                    i_valid    <= 1'b1;
                    i_req_type <= x.kind;
                    i_a_re     <= x.a_re;
                    i_a_im     <= x.a_im;
                    i_b_re     <= x.b_re;
                    i_b_im     <= x.b_im;
                    i_scale    <= x.scale;
                    // stretches of back-to-back requests come from drawing zero
                    send_wait  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end else begin
            i_valid    <= 1'b0;
            i_req_type <= '0;
            i_a_re     <= '0;
            i_a_im     <= '0;
            i_b_re     <= '0;
            i_b_im     <= '0;
            i_scale    <= '0;
            send_wait  <= 0;
        end
    end

    // monitor: random output stall, compares every accepted answer
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected answer", o_res_re, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (o_res_re !== want.re)   report_mismatch("res_re", o_res_re, want.re);
                    if (o_res_im !== want.im)   report_mismatch("res_im", o_res_im, want.im);
                    if (o_overflow !== want.ovf)
                        report_mismatch("overflow", o_overflow, want.ovf);
                    if (o_div_zero !== want.dz)
                        report_mismatch("div_zero", o_div_zero, want.dz);
                end
            end
            // draw a fresh stall length once per answer taken
            if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                i_stall   <= 1'b1;
            end else if (o_valid && !i_stall) begin
                recv_wait <= $urandom_range(0, 3);
                i_stall   <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end else begin
            i_stall   <= 1'b0;
            recv_wait <= 0;
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL complex_arith_unit_core");
            $finish;
        end
    end

    // end of run once everything has drained
    initial begin
        wait (stimulus_loaded);
        wait (i_rst_n);
        wait (pending_requests.size() == 0 && !i_valid);
        wait (expected_answers.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("PASS complex_arith_unit_core");
        else
            $display("FAIL complex_arith_unit_core");
        $finish;
    end

endmodule
